// ----- design/polyphase_analysis_filterbank_macros.svh -----
// Assertion macros for the filterbank RTL.
`ifndef POLYPHASE_ANALYSIS_FILTERBANK_MACROS_SVH
`define POLYPHASE_ANALYSIS_FILTERBANK_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define PAF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every clock edge, reset included.
`define PAF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PAF_ASSERT(lbl, prop, msg)
`define PAF_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- design/paf_pkg.sv -----
// Shared types, window and cosine tables for the polyphase analysis filterbank.
`timescale 1ns / 1ps
package paf_pkg;

  localparam int HIST_DEPTH = 512;
  localparam int NBANDS     = 32;
  localparam int YW         = 29;
  localparam int YPW        = 30;
  localparam int Q23W       = 25;

  typedef logic signed [17:0]     win_half_t;
  typedef logic signed [Q23W-1:0] q23_t;

  typedef struct packed {
    logic       win;
    logic [8:0] idx;
  } coef_req_t;

  localparam win_half_t WIN_HALF [257] = '{
    0,-1,-1,-1,-1,-1,-1,-2,-2,-2,-2,-3,-3,-4,-4,-5,
    -5,-6,-7,-7,-8,-9,-10,-11,-13,-14,-16,-17,-19,-21,-24,-26,
    -29,-31,-35,-38,-41,-45,-49,-53,-58,-63,-68,-73,-79,-85,-91,-97,
    -104,-111,-117,-125,-132,-139,-147,-154,-161,-169,-176,-183,-190,-196,-202,-208,
    -213,-218,-222,-225,-227,-228,-228,-227,-224,-221,-215,-208,-200,-189,-177,-163,
    -146,-127,-106,-83,-57,-29,2,36,72,111,153,197,244,294,347,401,
    459,519,581,645,711,779,848,919,991,1064,1137,1210,1283,1356,1428,1498,
    1567,1634,1698,1759,1817,1870,1919,1962,2001,2032,2057,2075,2085,2087,2080,2063,
    2037,2000,1952,1893,1822,1739,1644,1535,1414,1280,1131,970,794,605,402,185,
    -45,-288,-545,-814,-1095,-1388,-1692,-2006,-2330,-2663,-3004,-3351,-3705,-4063,
    -4425,-4788,
    -5153,-5517,-5879,-6237,-6589,-6935,-7271,-7597,-7910,-8209,-8491,-8755,-8998,
    -9219,-9416,-9585,
    -9727,-9838,-9916,-9959,-9966,-9935,-9863,-9750,-9592,-9389,-9139,-8840,-8492,
    -8092,-7640,-7134,
    -6574,-5959,-5288,-4561,-3776,-2935,-2037,-1082,-70,998,2122,3300,4533,5818,
    7154,8540,
    9975,11455,12980,14548,16155,17799,19478,21189,22929,24694,26482,28289,30112,
    31947,33791,35640,
    37489,39336,41176,43006,44821,46617,48390,50137,51853,53534,55178,56778,58333,
    59838,61289,62684,
    64019,65290,66494,67629,68692,69679,70590,71420,72169,72835,73415,73908,74313,
    74630,74856,74992,
    75038
  };

  localparam q23_t COS_QUARTER [33] = '{
    8388608, 8378504, 8348215, 8297814, 8227423, 8137212, 8027397, 7898244,
    7750063, 7583212, 7398092, 7195149, 6974873, 6737793, 6484482, 6215549,
    5931642, 5633445, 5321677, 4997088, 4660461, 4312606, 3954362, 3586592,
    3210181, 2826037, 2435084, 2038265, 1636536, 1230864, 822227, 411609, 0
  };

  // Window tap in Q1.23, mirrored from the half table.
  function automatic q23_t win_q23(input logic [8:0] i);
    logic [8:0] j;
    q23_t       v;
    j = (i <= 9'd256) ? i : 9'(10'd512 - {1'b0, i});
    v = q23_t'(WIN_HALF[j]) <<< 2;
    if (j[6]) v = -v;
    if (i > 9'd256 && j[5:0] != 6'd0) v = -v;
    return v;
  endfunction

  // cos(n*pi/64) in Q1.23 for n taken mod 128.
  function automatic q23_t cos_q23(input logic [6:0] n);
    logic [6:0] m;
    q23_t       v;
    m = (n > 7'd64) ? 7'(8'd128 - {1'b0, n}) : n;
    if (m <= 7'd32) v = COS_QUARTER[m[5:0]];
    else v = -COS_QUARTER[6'(7'd64 - m)];
    return v;
  endfunction

endpackage

// ----- design/polyphase_analysis_filterbank.sv -----
// Top level of the 32-band polyphase analysis filterbank.
`timescale 1ns / 1ps
`include "polyphase_analysis_filterbank_macros.svh"
// Accepts one PCM sample per transfer and stores it in its channel's 512-entry
// history memory. Every 32nd sample of a channel starts a block computation:
// 512 window multiply-accumulates through one shared multiplier, the 64 partial
// sums kept in a small two-read memory, then 512 cosine-matrix MACs with the
// even/odd fold applied on the fly, results parked in a 32-entry band buffer.
// The 32 bands then leave in order, each read, loaded and held through the
// S_ORD, S_OLD and S_OWT states, with out_last on band 31. A sample that does
// not complete a block leaves in_ready high; a completing sample keeps in_ready
// low through the window and matrix passes and the output drain, all set by the
// single MAC unit and the one-port history read. After reset a clearing pass
// writes zeros through the history before in_ready rises.
// Channel codes at or above CHANNELS are taken and dropped.
module polyphase_analysis_filterbank import paf_pkg::*; #(
  parameter int CHANNELS   = 2,
  parameter int COEF_WIDTH = 24
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_channel,
  input  logic signed [15:0] in_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_channel,
  output logic [4:0]         out_band,
  output logic signed [23:0] out_band_value,
  output logic               out_last
);

  localparam int DEPTH = CHANNELS * HIST_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int F     = COEF_WIDTH - 1;
  localparam int PW    = YPW + COEF_WIDTH;
  localparam int SW    = PW + 5;

  localparam logic signed [SW+8:0] RNDW = (SW+9)'(1) <<< (F - 1);
  localparam logic signed [SW:0]   RND  = (SW+1)'(1) <<< (F - 1);
  localparam logic signed [SW:0]   VMAX = (SW+1)'(8388607);
  localparam logic signed [SW:0]   VMIN = -VMAX - (SW+1)'(1);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WIN   = 4'd2;
  localparam logic [3:0] S_WWAIT = 4'd3;
  localparam logic [3:0] S_MAT   = 4'd4;
  localparam logic [3:0] S_MWAIT = 4'd5;
  localparam logic [3:0] S_ORD   = 4'd6;
  localparam logic [3:0] S_OLD   = 4'd7;
  localparam logic [3:0] S_OWT   = 4'd8;

  // Control state.
  logic [3:0]    state_r, state_nxt;
  logic [8:0]    cnt_r, cnt_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [8:0]    wptr_r [CHANNELS];
  logic          ch_r;
  logic [8:0]    pos_r;
  logic [4:0]    d_r;

  // Memories.
  logic signed [15:0]   hist_mem [DEPTH];
  logic signed [YW-1:0] y_mem [64];
  logic signed [23:0]   band_mem [NBANDS];
  logic signed [15:0]   hist_q;
  logic signed [YW-1:0] ya_q, yb_q;
  logic signed [23:0]   band_q;

  logic                 hist_we;
  logic [AW-1:0]        hist_wa, hist_ra;
  logic signed [15:0]   hist_wd;
  logic [5:0]           y_ra_a, y_ra_b;

  // MAC pipeline.
  coef_req_t                    creq;
  logic signed [COEF_WIDTH-1:0] coef_q;
  logic                         t1_v_r, ta_v_r, tb_v_r;
  logic                         t1_last_r, ta_last_r, tb_last_r;
  logic [5:0]                   t1_idx_r, ta_idx_r, tb_idx_r;
  logic [4:0]                   t1_k_r, ta_k_r, tb_k_r;
  logic signed [YPW-1:0]        mul_a_r;
  logic signed [COEF_WIDTH-1:0] mul_b_r;
  logic signed [PW-1:0]         prod_r;
  logic signed [SW-1:0]         s0_r, s1_r, fin_s0_r, fin_s1_r;
  logic                         fin_v_r, hi_v_r;
  logic [3:0]                   fin_i_r;
  logic [4:0]                   hi_idx_r;
  logic signed [23:0]           hi_r;

  logic                         out_valid_r, out_channel_r, out_last_r;
  logic [4:0]                   out_band_r;
  logic signed [23:0]           out_value_r;

  logic        in_fire, ch_ok, mat_ph;
  logic [8:0]  tap;
  logic [3:0]  mi;
  logic [4:0]  mk;
  logic [6:0]  n_cos;
  logic        iss_v, iss_last;
  logic [5:0]  iss_idx;
  logic signed [YPW-1:0] yp;
  logic signed [SW-1:0]  prod_x, wsum;
  logic signed [SW+8:0]  wt;
  logic signed [SW:0]    lo_t, hi_t;

  function automatic logic signed [23:0] sat24(input logic signed [SW:0] v);
    if (v > VMAX) return 24'sh7fffff;
    if (v < VMIN) return -24'sh800000;
    return 24'(v);
  endfunction

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign ch_ok    = (32'(in_channel) < CHANNELS);
  assign mat_ph   = (state_r == S_MAT) || (state_r == S_MWAIT);

  // Sequencing indexes: window taps run i-major, matrix runs band-pair-major.
  assign tap   = {cnt_r[2:0], cnt_r[8:3]};
  assign mi    = cnt_r[8:5];
  assign mk    = cnt_r[4:0];
  assign n_cos = 7'(10'({mi, 1'b1}) * 10'(mk));

  assign y_ra_a = 6'(6'd16 + {1'b0, mk});
  assign y_ra_b = (mk <= 5'd16) ? 6'(6'd16 - {1'b0, mk}) : 6'(7'd80 - {2'b0, mk});

  assign creq.win = (state_r == S_WIN);
  assign creq.idx = (state_r == S_WIN) ? tap : {2'b0, n_cos};

  assign iss_v    = (state_r == S_WIN) || (state_r == S_MAT);
  assign iss_last = (state_r == S_WIN) ? (cnt_r[2:0] == 3'd7) : (mk == 5'd31);
  assign iss_idx  = (state_r == S_WIN) ? cnt_r[8:3] : {2'b0, mi};

  paf_coef #(.COEF_WIDTH(COEF_WIDTH)) u_coef (
    .clk    (clk),
    .req    (creq),
    .coef_r (coef_q)
  );

  // History port: clear pass, sample write, window read.
  always_comb begin
    hist_we = 1'b0;
    hist_wa = clr_r;
    hist_wd = 16'sd0;
    if (state_r == S_CLR) begin
      hist_we = 1'b1;
    end else if (in_fire && ch_ok) begin
      hist_we = 1'b1;
      hist_wa = AW'({in_channel, wptr_r[in_channel]});
      hist_wd = in_sample;
    end
  end

  assign hist_ra = AW'({ch_r, 9'(pos_r - tap)});

  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_q <= hist_mem[hist_ra];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    unique case (state_r)
      S_CLR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire && ch_ok && wptr_r[in_channel][4:0] == 5'd31) begin
          state_nxt = S_WIN;
          cnt_nxt   = 9'd0;
        end
      end
      S_WIN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 9'd511) state_nxt = S_WWAIT;
      end
      S_WWAIT: begin
        if (tb_v_r && tb_last_r && tb_idx_r == 6'd63) begin
          state_nxt = S_MAT;
          cnt_nxt   = 9'd0;
        end
      end
      S_MAT: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 9'd511) state_nxt = S_MWAIT;
      end
      S_MWAIT: begin
        // the high half of the last band pair lands on band 16
        if (hi_v_r && hi_idx_r == 5'd16) state_nxt = S_ORD;
      end
      S_ORD: state_nxt = S_OLD;
      S_OLD: state_nxt = S_OWT;
      S_OWT: begin
        if (out_ready) state_nxt = (d_r == 5'd31) ? S_IDLE : S_ORD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      clr_r   <= '0;
      d_r     <= '0;
      for (int c = 0; c < CHANNELS; c++) wptr_r[c] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      clr_r   <= clr_nxt;
      if (in_fire && ch_ok) wptr_r[in_channel] <= wptr_r[in_channel] + 1'b1;
      if (state_r == S_MWAIT) d_r <= '0;
      else if (state_r == S_OWT && out_ready) d_r <= d_r + 1'b1;
    end
  end

  // Capture the block position of the completing sample.
  always_ff @(posedge clk) begin
    if (in_fire && ch_ok) begin
      ch_r  <= in_channel;
      pos_r <= wptr_r[in_channel];
    end
  end

  // Partial-sum memory: one write, two registered reads for the fold.
  always_comb begin
    prod_x = SW'(prod_r);
    wsum   = s0_r + prod_x;
    wt     = ((SW+9)'(wsum) <<< 8) + RNDW;
    yp     = YPW'(ya_q);
    if (t1_k_r == 5'd0) yp = YPW'(ya_q);
    else if (t1_k_r <= 5'd16) yp = YPW'(ya_q) + YPW'(yb_q);
    else yp = YPW'(ya_q) - YPW'(yb_q);
  end

  always_ff @(posedge clk) begin
    if (!mat_ph && tb_v_r && tb_last_r) y_mem[tb_idx_r] <= YW'(wt >>> F);
    ya_q <= y_mem[y_ra_a];
    yb_q <= y_mem[y_ra_b];
  end

  // Tag pipeline: issue, memory out, operands, product.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_v_r  <= 1'b0;
      ta_v_r  <= 1'b0;
      tb_v_r  <= 1'b0;
      fin_v_r <= 1'b0;
      hi_v_r  <= 1'b0;
    end else begin
      t1_v_r  <= iss_v;
      ta_v_r  <= t1_v_r;
      tb_v_r  <= ta_v_r;
      fin_v_r <= mat_ph && tb_v_r && tb_last_r;
      hi_v_r  <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_last_r <= iss_last;
    t1_idx_r  <= iss_idx;
    t1_k_r    <= mk;
    ta_last_r <= t1_last_r;
    ta_idx_r  <= t1_idx_r;
    ta_k_r    <= t1_k_r;
    tb_last_r <= ta_last_r;
    tb_idx_r  <= ta_idx_r;
    tb_k_r    <= ta_k_r;
    mul_a_r   <= mat_ph ? yp : YPW'(hist_q);
    mul_b_r   <= coef_q;
    prod_r    <= PW'(mul_a_r * mul_b_r);
  end

  // Accumulate: window sums in s0; matrix splits even and odd cosine terms.
  always_ff @(posedge clk) begin
    if (tb_v_r) begin
      if (!mat_ph) begin
        s0_r <= tb_last_r ? '0 : wsum;
      end else begin
        if (tb_k_r == 5'd0) begin
          s0_r <= prod_x;
          s1_r <= '0;
        end else if (!tb_k_r[0]) begin
          s0_r <= s0_r + prod_x;
        end else begin
          s1_r <= s1_r + prod_x;
        end
        if (tb_last_r) begin
          fin_s0_r <= s0_r;
          fin_s1_r <= s1_r + prod_x;
          fin_i_r  <= tb_idx_r[3:0];
        end
      end
    end else if (state_r == S_IDLE) begin
      s0_r <= '0;
    end
  end

  always_comb begin
    lo_t = ((SW+1)'(fin_s0_r) + (SW+1)'(fin_s1_r) + RND) >>> F;
    hi_t = ((SW+1)'(fin_s0_r) - (SW+1)'(fin_s1_r) + RND) >>> F;
  end

  // Band buffer: low band of a pair first, high band in the following cycle.
  always_ff @(posedge clk) begin
    hi_r     <= sat24(hi_t);
    hi_idx_r <= 5'd31 - {1'b0, fin_i_r};
    if (fin_v_r) band_mem[{1'b0, fin_i_r}] <= sat24(lo_t);
    else if (hi_v_r) band_mem[hi_idx_r] <= hi_r;
    band_q <= band_mem[d_r];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OLD) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OLD) begin
      out_value_r   <= band_q;
      out_band_r    <= d_r;
      out_channel_r <= ch_r;
      out_last_r    <= (d_r == 5'd31);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_band       = out_band_r;
  assign out_band_value = out_value_r;
  assign out_last       = out_last_r;

  `PAF_ASSERT(a_no_out_when_ready, in_ready |-> !out_valid, "input taken during drain")
  `PAF_ASSERT(a_last_is_top_band, out_valid && out_last |-> out_band == 5'd31,
    "last flag off band 31")
  `PAF_ASSERT(a_idle_after_last, out_valid && out_ready && out_last |=> in_ready,
    "block did not return to idle after last band")
  `PAF_ASSERT_ALWAYS(a_clear_after_reset, !rst_n |=> !in_ready,
    "input accepted before history clear")

endmodule

// ----- design/paf_coef.sv -----
// Registered coefficient generator: window and cosine taps in Q1.F.
`timescale 1ns / 1ps
module paf_coef import paf_pkg::*; #(
  parameter int COEF_WIDTH = 24
) (
  input  logic                         clk,
  input  coef_req_t                    req,
  output logic signed [COEF_WIDTH-1:0] coef_r
);

  localparam int F    = COEF_WIDTH - 1;
  localparam int UP   = (COEF_WIDTH >= 24) ? COEF_WIDTH - 24 : 0;
  localparam int DN   = (COEF_WIDTH < 24) ? 24 - COEF_WIDTH : 0;
  localparam int HALF = (DN > 0) ? (1 << (DN - 1)) : 0;
  localparam logic signed [40:0] TOP = (41'sd1 <<< F) - 41'sd1;

  logic signed [40:0] q;
  logic signed [40:0] t;

  always_comb begin
    q = req.win ? 41'(win_q23(req.idx)) : 41'(cos_q23(req.idx[6:0]));
    t = ((q <<< UP) + 41'(HALF)) >>> DN;
    // clamp cosine of one
    if (!req.win && t > TOP) t = TOP;
  end

  always_ff @(posedge clk) begin
    coef_r <= COEF_WIDTH'(t);
  end

endmodule
